/* sv/slac_pkg.sv */
// shared constants and helpers for the s-box linear approximation count block
// no dependencies
package slac_pkg;

  localparam int MAX_IN_BITS  = 8;
  localparam int MAX_OUT_BITS = 8;
  localparam int TABLE_DEPTH  = 1 << MAX_IN_BITS;
  localparam int CNT_W        = MAX_IN_BITS + 1;
  localparam int BITS_W       = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BITS = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // clamp a bit count to 1..maxv
  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] v,
                                                   input logic [BITS_W-1:0] maxv);
    logic [BITS_W-1:0] r;
    if (v == '0) begin
      r = BITS_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* sv/slac_table.sv */
// single-port s-box table memory with registered read data
// depends on slac_pkg
module slac_table import slac_pkg::*; (
  input  logic                    clk,
  input  logic                    we,
  input  logic [MAX_IN_BITS-1:0]  addr,
  input  logic [MAX_OUT_BITS-1:0] wdata,
  output logic [MAX_OUT_BITS-1:0] rdata
);

  logic [MAX_OUT_BITS-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/sbox_linear_approximation_count_core.sv */
// top level of the s-box linear approximation count block
// depends on slac_pkg and slac_table
//
// channel  direction  fields                                            handshake
// -------  ---------  ------------------------------------------------  -------------------
// in       input      op entry_index entry_value in_mask out_mask        in_valid/in_ready
// out      output     mismatch_count const_bit                          out_valid/out_ready
// cfg      input      cfg_index cfg_data                                cfg_write
//
// a load transfer writes one table entry and gives no result
// a query walks 2^n table entries (n is in_bits clamped to 1..8) through the single
// memory port, one per cycle; the count then passes ST_DRAIN and ST_DONE to the result register
// in_ready is low from the query transfer until the count moves to the output
// register, which waits while an earlier result is still held there
// rst is synchronous, active high; the table has no reset and no clearing pass
module sbox_linear_approximation_count_core import slac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [BITS_W-1:0]       cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [MAX_IN_BITS-1:0]  entry_index,
  input  logic [MAX_OUT_BITS-1:0] entry_value,
  input  logic [MAX_IN_BITS-1:0]  in_mask,
  input  logic [MAX_OUT_BITS-1:0] out_mask,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CNT_W-1:0]        mismatch_count,
  output logic                    const_bit
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a transfer
  localparam logic [1:0] ST_RUN   = 2'd1;  // issuing table reads
  localparam logic [1:0] ST_DRAIN = 2'd2;  // last read data comes back
  localparam logic [1:0] ST_DONE  = 2'd3;  // count final, wait for output register

  logic [1:0]              state;
  logic [BITS_W-1:0]       in_bits;
  logic [BITS_W-1:0]       out_bits;

  // query context, latched at the query transfer
  logic [BITS_W-1:0]       n_q;
  logic [MAX_IN_BITS-1:0]  imask_q;
  logic [MAX_OUT_BITS-1:0] omask_q;
  logic [MAX_IN_BITS-1:0]  last_x;

  // walk counter and read pipeline
  logic [MAX_IN_BITS-1:0]  x;
  logic [MAX_IN_BITS-1:0]  x_d;
  logic                    rd_valid;
  logic [CNT_W-1:0]        cnt;

  logic                    in_xfer;
  logic                    load_we;
  logic [MAX_IN_BITS-1:0]  mem_addr;
  logic [MAX_OUT_BITS-1:0] mem_rdata;
  logic                    out_free;
  logic [BITS_W-1:0]       n_now;
  logic [BITS_W-1:0]       m_now;
  logic [CNT_W-1:0]        size_now;
  logic [MAX_OUT_BITS:0]   omask_wide;
  logic                    mismatch;
  logic [CNT_W-1:0]        half;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign load_we  = in_xfer && (op == OP_LOAD);
  assign out_free = !out_valid || out_ready;

  // effective widths for a new query
  assign n_now      = clamp_bits(in_bits, BITS_W'(MAX_IN_BITS));
  assign m_now      = clamp_bits(out_bits, BITS_W'(MAX_OUT_BITS));
  assign size_now   = CNT_W'(1) << n_now;
  assign omask_wide = (MAX_OUT_BITS+1)'(1) << m_now;

  // the memory port serves the load while idle and the walk otherwise
  assign mem_addr = (state == ST_IDLE) ? entry_index : x;

  slac_table u_table (
    .clk   (clk),
    .we    (load_we),
    .addr  (mem_addr),
    .wdata (entry_value),
    .rdata (mem_rdata)
  );

  // one entry's contribution: input parity against output parity
  assign mismatch = (^(imask_q & x_d)) ^ (^(omask_q & mem_rdata));
  assign half     = CNT_W'(1) << (n_q - BITS_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_bits  <= BITS_W'(8);
      out_bits <= BITS_W'(8);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IN_BITS:  in_bits  <= cfg_data;
        REG_OUT_BITS: out_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result loads as the old one leaves, so the set wins over the clear
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_valid <= 1'b0;
          if (in_xfer && (op == OP_QUERY)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          rd_valid <= 1'b1;
          if (x == last_x) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          rd_valid <= 1'b0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          rd_valid <= 1'b0;
          if (out_free) begin
            state     <= ST_IDLE;
          end
        end
        default: begin
          rd_valid <= 1'b0;
          state    <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: query context, walk counter, accumulator, result register
  always_ff @(posedge clk) begin
    if (in_xfer && (op == OP_QUERY)) begin
      n_q     <= n_now;
      imask_q <= in_mask;
      omask_q <= out_mask & omask_wide[MAX_OUT_BITS-1:0] - MAX_OUT_BITS'(1);
      last_x  <= MAX_IN_BITS'(size_now - CNT_W'(1));
      x       <= '0;
      cnt     <= '0;
    end else begin
      if (state == ST_RUN) begin
        x_d <= x;
        x   <= x + MAX_IN_BITS'(1);
      end
      if (rd_valid) begin
        cnt <= cnt + CNT_W'(mismatch);
      end
    end
    if ((state == ST_DONE) && out_free) begin
      mismatch_count <= cnt;
      const_bit      <= (cnt >= half);
    end
  end

endmodule

/* sv/slac_checker.sv */
// port-level checks for the s-box linear approximation count core, with its bind
// depends on slac_pkg and sbox_linear_approximation_count_core
module slac_checker import slac_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    op,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CNT_W-1:0]        mismatch_count,
  input logic                    const_bit
);

  // a result that waits keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mismatch_count) && $stable(const_bit))
    else $error("result changed while stalled");

  // a query transfer closes the input side for the walk
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_QUERY) |=> !in_ready)
    else $error("input taken during a table walk");

  // the count never passes the table depth
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mismatch_count <= CNT_W'(TABLE_DEPTH)))
    else $error("count above table depth");

  // a load never produces a result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("result after a load");

endmodule

bind sbox_linear_approximation_count_core slac_checker u_slac_checker (.*);

/* sim/sbox_lat_checker.sv */
`timescale 1ns / 1ps
// result checker for the s-box linear approximation count core
// watches the cfg, in and out channels, keeps its own table copy and widths
// depends on slac_pkg
module sbox_lat_checker import slac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [BITS_W-1:0]       cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    op,
  input  logic [MAX_IN_BITS-1:0]  entry_index,
  input  logic [MAX_OUT_BITS-1:0] entry_value,
  input  logic [MAX_IN_BITS-1:0]  in_mask,
  input  logic [MAX_OUT_BITS-1:0] out_mask,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [CNT_W-1:0]        mismatch_count,
  input  logic                    const_bit,
  output int                      failures,
  output int                      pending
);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             half_or_more;
  } lat_result_t;

  logic [MAX_OUT_BITS-1:0] sbox_copy [TABLE_DEPTH];
  logic [BITS_W-1:0]       in_width;
  logic [BITS_W-1:0]       out_width;
  lat_result_t             expected_counts [$];
  lat_result_t             oldest;

  // walk 2^n inputs and count where the input and output mask parities differ
  function automatic lat_result_t count_parity_mismatches(input logic [MAX_IN_BITS-1:0] imask,
                                                          input logic [MAX_OUT_BITS-1:0] omask);
    int                      n;
    int                      m;
    int                      span;
    int                      cnt;
    logic [MAX_OUT_BITS-1:0] width_mask;
    lat_result_t             r;
    n = (in_width == 0) ? 1 : (in_width > MAX_IN_BITS) ? MAX_IN_BITS : int'(in_width);
    m = (out_width == 0) ? 1 : (out_width > MAX_OUT_BITS) ? MAX_OUT_BITS : int'(out_width);
    span = 1 << n;
    width_mask = MAX_OUT_BITS'((1 << m) - 1);
    cnt = 0;
    for (int x = 0; x < span; x++) begin
      cnt += int'((^(imask & MAX_IN_BITS'(x))) ^
                  (^(omask & width_mask & sbox_copy[MAX_IN_BITS'(x)])));
    end
    r.count = CNT_W'(cnt);
    r.half_or_more = (cnt >= span / 2);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_width <= BITS_W'(MAX_IN_BITS);
      out_width <= BITS_W'(MAX_OUT_BITS);
      expected_counts.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IN_BITS: begin
            in_width <= cfg_data;
          end
          REG_OUT_BITS: begin
            out_width <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        if (op == OP_LOAD) begin
          sbox_copy[entry_index] <= entry_value;
        end else begin
          expected_counts.push_back(count_parity_mismatches(in_mask, out_mask));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected result: mismatch_count %0d const_bit %0d",
                 mismatch_count, const_bit);
          failures++;
        end else begin
          oldest = expected_counts.pop_front();
          if (mismatch_count !== oldest.count) begin
            $error("mismatch_count: expected %0d, got %0d", oldest.count, mismatch_count);
            failures++;
          end
          if (const_bit !== oldest.half_or_more) begin
            $error("const_bit: expected %0d, got %0d", oldest.half_or_more, const_bit);
            failures++;
          end
        end
      end
      pending <= expected_counts.size();
    end
  end

endmodule

/* sim/sbox_linear_approximation_count_core_test.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the s-box linear approximation count core
// depends on slac_pkg, the core rtl and sbox_lat_checker
module sbox_linear_approximation_count_core_test;
  import slac_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RANDOM_ITEMS  = 1930;
  localparam int LONG_GAP_MAX  = 48;
  localparam int HOLD_AT       = 900;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 8;
  // worst case: every item a full-table query behind the longest gaps on both sides
  localparam int MAX_ITEMS     = RANDOM_ITEMS + TABLE_DEPTH + 300;
  localparam int CYCLE_LIMIT   =
    3 * (MAX_ITEMS * (TABLE_DEPTH + 3 + 2 * LONG_GAP_MAX) + HOLD_CYCLES);

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [BITS_W-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    op;
  logic [MAX_IN_BITS-1:0]  entry_index;
  logic [MAX_OUT_BITS-1:0] entry_value;
  logic [MAX_IN_BITS-1:0]  in_mask;
  logic [MAX_OUT_BITS-1:0] out_mask;
  logic                    out_valid;
  logic                    out_ready;
  logic [CNT_W-1:0]        mismatch_count;
  logic                    const_bit;

  int                      failures;
  int                      pending;
  int                      cycles;
  int                      items_sent;
  int                      span;        // table entries a query walks at the current width
  bit [TABLE_DEPTH-1:0]    loaded;      // entries written since reset
  bit                      steady_in;   // phase with no sender gaps
  bit                      hold_done;

  sbox_linear_approximation_count_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .in_mask        (in_mask),
    .out_mask       (out_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mismatch_count (mismatch_count),
    .const_bit      (const_bit)
  );

  sbox_lat_checker count_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .in_mask        (in_mask),
    .out_mask       (out_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mismatch_count (mismatch_count),
    .const_bit      (const_bit),
    .failures       (failures),
    .pending        (pending)
  );

  // 12 ns clock, first rising edge at 6 ns
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly back-to-back, sometimes a few cycles, rarely a long pause
  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(13, LONG_GAP_MAX);
  endfunction

  // masks and values lean toward all-zero and all-one
  function automatic logic [7:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  // one register write, then a quiet wait so write enable drops cleanly
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BITS_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item and hold it until the transfer, then maybe back off
  task automatic send_item(input logic o, input logic [7:0] idx, input logic [7:0] val,
                           input logic [7:0] im, input logic [7:0] om);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    entry_index <= idx;
    entry_value <= val;
    in_mask <= im;
    out_mask <= om;
    do @(posedge clk); while (!in_ready);
    if (o == OP_LOAD) begin
      loaded[idx] = 1'b1;
    end
    items_sent++;
    gap = pick_gap(steady_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // load: mask fields carry noise
  task automatic load_entry(input logic [7:0] idx, input logic [7:0] val);
    send_item(OP_LOAD, idx, val, 8'($urandom), 8'($urandom));
  endtask

  // query: entry fields carry noise; only issued once the walked span is loaded
  task automatic query_masks(input logic [7:0] im, input logic [7:0] om);
    send_item(OP_QUERY, 8'($urandom), 8'($urandom), im, om);
  endtask

  // wait out every outstanding result, then the tail of a trailing load
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new widths on an idle block, then load whatever the new span still lacks
  task automatic start_phase(input logic [BITS_W-1:0] in_raw, input logic [BITS_W-1:0] out_raw);
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_IN_BITS, in_raw);
      write_reg(REG_OUT_BITS, out_raw);
    end else begin
      write_reg(REG_OUT_BITS, out_raw);
      write_reg(REG_IN_BITS, in_raw);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, BITS_W'($urandom));
    end
    span = 1 << clamp_bits(in_raw, BITS_W'(MAX_IN_BITS));
    for (int i = 0; i < span; i++) begin
      if (!loaded[MAX_IN_BITS'(i)]) begin
        load_entry(8'(i), pick_mask());
      end
    end
  endtask

  // receiver: random ready pattern, long ready runs, and one long hold-off
  // in the middle of the random part so the output register and the walk back up
  initial begin
    int run;
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // sender: reset, directed corner items, then random phases at varied widths
  initial begin
    int                phase;
    int                phase_len;
    int                r;
    logic [BITS_W-1:0] in_raw;
    logic [BITS_W-1:0] out_raw;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IN_BITS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_LOAD;
    entry_index <= '0;
    entry_value <= '0;
    in_mask <= '0;
    out_mask <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero widths act as one bit; undecoded register indexes must change nothing
    write_reg(REG_IN_BITS, 4'd0);
    write_reg(REG_OUT_BITS, 4'd0);
    write_reg(REG_SPARE_A, 4'hF);
    write_reg(REG_SPARE_B, 4'h3);
    span = 2;
    load_entry(8'h00, 8'hFF);
    load_entry(8'h01, 8'h00);
    load_entry(8'hFF, 8'hA5);   // top index, outside the walked span
    query_masks(8'h00, 8'h00);  // both masks zero
    query_masks(8'hFF, 8'hFF);  // mask bits above the widths
    query_masks(8'h01, 8'h01);
    query_masks(8'hFE, 8'hFE);  // only bits above the widths set
    query_masks(8'h00, 8'h01);
    query_masks(8'h01, 8'h00);

    // two input bits, output width above the maximum acts as eight
    start_phase(4'd2, 4'd15);
    load_entry(8'h02, 8'h80);
    load_entry(8'h03, 8'h7F);
    query_masks(8'h03, 8'h80);
    query_masks(8'h00, 8'hFF);
    query_masks(8'h02, 8'h7F);
    query_masks(8'hFF, 8'h00);

    // random phases: full widths first, then clamped extremes, then a weighted mix
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        in_raw = 4'd8;
        out_raw = 4'd8;
      end else if (phase == 1) begin
        in_raw = 4'd15;
        out_raw = 4'd0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          in_raw = 4'd0;
        end else if (r < 50) begin
          in_raw = BITS_W'($urandom_range(1, 4));
        end else if (r < 72) begin
          in_raw = BITS_W'($urandom_range(5, 7));
        end else if (r < 88) begin
          in_raw = 4'd8;
        end else begin
          in_raw = BITS_W'($urandom_range(9, 15));
        end
        out_raw = BITS_W'($urandom_range(0, 15));
      end
      start_phase(in_raw, out_raw);
      steady_in = ($urandom_range(0, 3) == 0);
      // full-table walks are slow, so those phases stay short
      phase_len = (span == TABLE_DEPTH) ? $urandom_range(40, 100) : $urandom_range(80, 200);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          query_masks(pick_mask(), pick_mask());
        end else if (r < 85) begin
          load_entry(8'($urandom_range(0, span - 1)), pick_mask());
        end else begin
          load_entry(8'($urandom), pick_mask());
        end
      end
      phase++;
    end

    wait_idle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
